### hdl/lbpt_pkg.sv
// lbpt_pkg: shared constants for the line bit-plane transpose block
// register map codes, word widths and line store limits; no dependencies
`default_nettype none

package lbpt_pkg;

    localparam int MAX_LINE_DEF = 64;
    localparam int WORD_NARROW  = 16;
    localparam int WORD_WIDE    = 32;
    localparam int DATA_W       = 32;
    localparam int APB_ADDR_W   = 4;
    localparam int LEN_REG_W    = 7;

    typedef enum logic [1:0] {
        REG_WIDE_WORDS  = 2'd0,
        REG_INVERSE     = 2'd1,
        REG_LINE_LENGTH = 2'd2
    } reg_index_t;

endpackage

`default_nettype wire

### hdl/lbpt_ram.sv
// lbpt_ram: generic single write port, single read port ram with registered read
// used as the line store; depends on nothing
`default_nettype none

module lbpt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### hdl/line_bit_plane_transpose_core.sv
// line_bit_plane_transpose_core: top level of the line bit-plane transpose block
// depends on lbpt_pkg and lbpt_ram (line store)
//
// usage:
//   input channel (in_valid/in_ready, word_in): one beat per pixel word of a line.
//   input beats are taken one per cycle; in_ready is high only while loading a line.
//   when line_length words are in (0 reads as 1, above MAX_LINE as MAX_LINE),
//   the block gathers the transposed line and sends line_length beats on the
//   output channel (out_valid/out_ready, word_out, last), last marking the final one.
//   every output word is built one bit per cycle through the single read port of
//   the line store, 16 bits in 16-bit mode and 32 in 32-bit mode, and each word
//   then passes through the drain and output states before the next is gathered.
//   the output register lets the next word be gathered while one waits; when the
//   receiver stalls the gathering holds at the end of that next word.
//   config (apb, pready tied high): 0x0 wide_words, 0x4 inverse, 0x8 line_length;
//   write only while idle. reset clears registers to 16-bit, forward, length 64,
//   empties the line and drops any pending output; the store is not cleared.
`default_nettype none

module line_bit_plane_transpose_core
    import lbpt_pkg::*;
#(
    parameter int MAX_LINE = MAX_LINE_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [DATA_W-1:0]     word_in,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic      [DATA_W-1:0]     word_out,
    output logic                       last,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0]     pwdata,
    output logic      [DATA_W-1:0]     prdata,
    output logic                       pready
);

    localparam int AW = $clog2(MAX_LINE);
    localparam int LW = $clog2(MAX_LINE + 1);
    localparam int BW = $clog2(WORD_WIDE * MAX_LINE);

    typedef enum logic [1:0] {
        S_LOAD,
        S_GATHER,
        S_DRAIN,
        S_OUT
    } state_t;

    state_t state_reg;

    logic                 wide_reg;
    logic                 inverse_reg;
    logic [LEN_REG_W-1:0] line_length_reg;

    logic [LW-1:0]     loaded_reg;
    logic [AW-1:0]     xo_reg;
    logic [4:0]        io_reg;
    logic [AW-1:0]     fwd_word_reg;
    logic [4:0]        fwd_bit_reg;
    logic [BW-1:0]     inv_pos_reg;
    logic [DATA_W-1:0] acc_reg;
    logic              pend_reg;
    logic [4:0]        pend_io_reg;
    logic [4:0]        pend_bit_reg;
    logic              out_valid_reg;
    logic [DATA_W-1:0] word_out_reg;
    logic              last_reg;

    logic [LEN_REG_W-1:0] len_sat;
    logic [LW-1:0]        len;
    logic [LW-1:0]        len_m1;
    logic [LW-1:0]        loaded_next;
    logic [4:0]           io_last;
    logic                 xo_last;
    logic                 in_fire;
    logic                 cfg_write;
    logic                 out_free;
    logic [AW-1:0]        rd_addr;
    logic [4:0]           rd_bit;
    logic [DATA_W-1:0]    rd_data;

    // effective line length
    always_comb
    begin
        if (line_length_reg == '0)
        begin
            len_sat = LEN_REG_W'(1);
        end
        else if (line_length_reg > LEN_REG_W'(MAX_LINE))
        begin
            len_sat = LEN_REG_W'(MAX_LINE);
        end
        else
        begin
            len_sat = line_length_reg;
        end
    end

    assign len         = len_sat[LW-1:0];
    assign len_m1      = len - LW'(1);
    assign loaded_next = loaded_reg + LW'(1);
    assign io_last     = wide_reg ? 5'(WORD_WIDE - 1) : 5'(WORD_NARROW - 1);
    assign xo_last     = (LW'(xo_reg) == len_m1);
    assign in_ready    = (state_reg == S_LOAD);
    assign in_fire     = in_valid && in_ready;
    assign out_free    = !out_valid_reg || out_ready;
    assign cfg_write   = psel && penable && pwrite && pready;

    // forward: position walks word index fastest; inverse: bit position by
    // stepping the flat bit offset by the line length
    always_comb
    begin
        if (inverse_reg)
        begin
            if (wide_reg)
            begin
                rd_addr = AW'(inv_pos_reg >> 5);
                rd_bit  = inv_pos_reg[4:0];
            end
            else
            begin
                rd_addr = AW'(inv_pos_reg >> 4);
                rd_bit  = {1'b0, inv_pos_reg[3:0]};
            end
        end
        else
        begin
            rd_addr = fwd_word_reg;
            rd_bit  = fwd_bit_reg;
        end
    end

    lbpt_ram #(
        .WIDTH(DATA_W),
        .DEPTH(MAX_LINE)
    ) u_line_store (
        .clk  (clk),
        .we   (in_fire),
        .waddr(loaded_reg[AW-1:0]),
        .wdata(word_in),
        .raddr(rd_addr),
        .rdata(rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_reg        <= 1'b0;
            inverse_reg     <= 1'b0;
            line_length_reg <= LEN_REG_W'(64);
        end
        else if (cfg_write)
        begin
            unique case (paddr[APB_ADDR_W-1:2])
                REG_WIDE_WORDS:  wide_reg        <= pwdata[0];
                REG_INVERSE:     inverse_reg     <= pwdata[0];
                REG_LINE_LENGTH: line_length_reg <= pwdata[LEN_REG_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[APB_ADDR_W-1:2])
            REG_WIDE_WORDS:  prdata = DATA_W'(wide_reg);
            REG_INVERSE:     prdata = DATA_W'(inverse_reg);
            REG_LINE_LENGTH: prdata = DATA_W'(line_length_reg);
            default:         prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            loaded_reg    <= '0;
            xo_reg        <= '0;
            io_reg        <= '0;
            fwd_word_reg  <= '0;
            fwd_bit_reg   <= '0;
            inv_pos_reg   <= '0;
            acc_reg       <= '0;
            pend_reg      <= 1'b0;
            pend_io_reg   <= '0;
            pend_bit_reg  <= '0;
            out_valid_reg <= 1'b0;
            word_out_reg  <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            pend_reg <= (state_reg == S_GATHER);
            if (state_reg == S_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            // read data lands in the cycle after its address
            if (pend_reg)
            begin
                acc_reg[pend_io_reg] <= rd_data[pend_bit_reg];
            end

            unique case (state_reg)
                S_LOAD:
                begin
                    if (in_fire)
                    begin
                        if (loaded_next >= len)
                        begin
                            loaded_reg   <= '0;
                            xo_reg       <= '0;
                            io_reg       <= '0;
                            fwd_word_reg <= '0;
                            fwd_bit_reg  <= '0;
                            inv_pos_reg  <= '0;
                            acc_reg      <= '0;
                            state_reg    <= S_GATHER;
                        end
                        else
                        begin
                            loaded_reg <= loaded_next;
                        end
                    end
                end
                S_GATHER:
                begin
                    pend_io_reg  <= io_reg;
                    pend_bit_reg <= rd_bit;
                    io_reg       <= io_reg + 5'd1;
                    inv_pos_reg  <= inv_pos_reg + BW'(len);
                    if (LW'(fwd_word_reg) == len_m1)
                    begin
                        fwd_word_reg <= '0;
                        fwd_bit_reg  <= fwd_bit_reg + 5'd1;
                    end
                    else
                    begin
                        fwd_word_reg <= fwd_word_reg + AW'(1);
                    end
                    if (io_reg == io_last)
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        word_out_reg  <= acc_reg;
                        last_reg      <= xo_last;
                        if (xo_last)
                        begin
                            state_reg <= S_LOAD;
                        end
                        else
                        begin
                            xo_reg      <= xo_reg + AW'(1);
                            io_reg      <= '0;
                            inv_pos_reg <= BW'(xo_reg) + BW'(1);
                            acc_reg     <= '0;
                            state_reg   <= S_GATHER;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign word_out  = word_out_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire
